>>> rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine: command and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;

   typedef enum logic [1:0] {
      CMD_FRONT  = 2'd0,
      CMD_BACK   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic       load;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_at_count;
      logic       wr_from_mem;
      cnt_op_type cnt_op;
      logic       out_load;
      status_type out_status;
      logic       out_last;
      logic       out_from_mem;
   } ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic idx_zero;
      logic idx_at_end;
      logic idx_tail;
      logic match;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/ole_req_if.sv
// ----------------------------------------------------------------------------
// ole_req_if
// Command channel: valid/ready handshake carrying command and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ole_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  command;
   logic signed [31:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/ole_rsp_if.sv
// ----------------------------------------------------------------------------
// ole_rsp_if
// Result channel: valid/ready handshake carrying item value, status, last.
// ----------------------------------------------------------------------------
`default_nettype none

interface ole_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] item_value;
   logic        [1:0]  status;
   logic               last;

   modport source (output valid, output item_value, output status, output last,
                   input ready);
   modport sink   (input valid, input item_value, input status, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with front insert,
// back append, remove of the first match and a front-to-back dump.
//
// Usage: one command beat on req_chan (command, value). Every command gives
// one result beat on rsp_chan, except a dump of a non-empty list, which gives
// one beat per entry, front first; last marks the final beat of a command.
// A new command is taken only once the previous one has finished; its final
// result may still sit in the output register at that point.
// Memory: one read port with registered data and one write port, so each moved
// entry takes a read step and then a write step.
// Reset empties the list; entries themselves are not cleared.
// A stalled rsp_chan holds the result register and pauses the sequence at
// its next result; list contents are never lost.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
   input  wire         clock,
   input  wire         reset,
   ole_req_if.sink     req_chan,
   ole_rsp_if.source   rsp_chan
);
   import ole_pkg::*;

   ctl_type            ctl;
   sts_type            sts;
   logic signed [31:0] out_value;
   status_type         out_status;
   logic               out_last;

   ole_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .sts         (sts),
      .ctl         (ctl)
   );

   ole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .value_i    (req_chan.value),
      .sts        (sts),
      .out_value  (out_value),
      .out_status (out_status),
      .out_last   (out_last)
   );

   assign rsp_chan.item_value = out_value;
   assign rsp_chan.status     = out_status;
   assign rsp_chan.last       = out_last;

endmodule

`default_nettype wire

>>> rtl/ole_datapath.sv
// ----------------------------------------------------------------------------
// ole_datapath
// Entry memory, entry count, cursor, operand register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_datapath #(
   parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ole_pkg::ctl_type     ctl,
   input  wire signed [31:0]    value_i,
   output ole_pkg::sts_type     sts,
   output logic signed [31:0]   out_value,
   output ole_pkg::status_type  out_status,
   output logic                 out_last
);
   import ole_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] operand_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic [VALUE_W-1:0] out_value_ff;
   status_type         out_status_ff;
   logic               out_last_ff;

   logic [CW-1:0]      idx_inc;
   logic [CW-1:0]      idx_dec;
   logic [CW:0]        idx_next_wide;
   logic [AW-1:0]      rd_addr;
   logic [CW-1:0]      wr_idx;
   logic [VALUE_W-1:0] wr_data;

   assign idx_inc       = idx_ff + CW'(1);
   assign idx_dec       = idx_ff - CW'(1);
   assign idx_next_wide = {1'b0, idx_ff} + (CW+1)'(1);

   always_comb begin
      case (ctl.rd_sel)
         RD_PREV: rd_addr = idx_dec[AW-1:0];
         RD_NEXT: rd_addr = idx_inc[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   assign wr_idx  = ctl.wr_at_count ? count_ff : idx_ff;
   assign wr_data = ctl.wr_from_mem ? rd_data_ff : operand_ff;

   always_comb begin
      case (ctl.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_COUNT: idx_in = count_ff;
         IDX_INC:   idx_in = idx_inc;
         IDX_DEC:   idx_in = idx_dec;
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (ctl.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_idx[AW-1:0]] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         operand_ff <= value_i;
      end
      if (ctl.out_load) begin
         out_value_ff  <= ctl.out_from_mem ? rd_data_ff : '0;
         out_status_ff <= ctl.out_status;
         out_last_ff   <= ctl.out_last;
      end
   end

   assign sts.full       = (count_ff == CW'(CAPACITY));
   assign sts.empty      = (count_ff == '0);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.idx_at_end = (idx_next_wide == {1'b0, count_ff});
   assign sts.idx_tail   = (idx_next_wide >= {1'b0, count_ff});
   assign sts.match      = (rd_data_ff == operand_ff);

   assign out_value  = out_value_ff;
   assign out_status = out_status_ff;
   assign out_last   = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> wr_idx < CW'(CAPACITY))
      else $error("write beyond list storage");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + CW'(1) ||
                         count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

endmodule

`default_nettype wire

>>> rtl/ole_controller.sv
// ----------------------------------------------------------------------------
// ole_controller
// Sequencer for insert, append, remove and dump; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_controller (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire  [1:0]        req_command,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  ole_pkg::sts_type  sts,
   output ole_pkg::ctl_type  ctl
);
   import ole_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_F_STEP,
      S_F_WRITE,
      S_R_READ,
      S_R_EVAL,
      S_SHIFT,
      S_S_WRITE,
      S_D_READ,
      S_D_EVAL
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      ctl.load         = 1'b0;
      ctl.idx_op       = IDX_HOLD;
      ctl.rd_en        = 1'b0;
      ctl.rd_sel       = RD_CUR;
      ctl.wr_en        = 1'b0;
      ctl.wr_at_count  = 1'b0;
      ctl.wr_from_mem  = 1'b0;
      ctl.cnt_op       = CNT_HOLD;
      ctl.out_load     = 1'b0;
      ctl.out_status   = ST_OK;
      ctl.out_last     = 1'b1;
      ctl.out_from_mem = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load   = 1'b1;
               cmd_in     = cmd_type'(req_command);
               ctl.idx_op = (cmd_type'(req_command) == CMD_FRONT) ? IDX_COUNT : IDX_ZERO;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (out_free) begin
               case (cmd_ff)
                  CMD_FRONT: begin
                     if (sts.full) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = ST_FULL;
                        state_in       = S_IDLE;
                     end else begin
                        state_in = S_F_STEP;
                     end
                  end
                  CMD_BACK: begin
                     ctl.out_load = 1'b1;
                     state_in     = S_IDLE;
                     if (sts.full) begin
                        ctl.out_status = ST_FULL;
                     end else begin
                        ctl.wr_en       = 1'b1;
                        ctl.wr_at_count = 1'b1;
                        ctl.cnt_op      = CNT_INC;
                     end
                  end
                  CMD_REMOVE: begin
                     if (sts.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = ST_NOT_FOUND;
                        state_in       = S_IDLE;
                     end else begin
                        state_in = S_R_READ;
                     end
                  end
                  default: begin
                     if (sts.empty) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = ST_EMPTY;
                        state_in       = S_IDLE;
                     end else begin
                        state_in = S_D_READ;
                     end
                  end
               endcase
            end
         end
         S_F_STEP: begin
            if (sts.idx_zero) begin
               if (out_free) begin
                  ctl.wr_en    = 1'b1;
                  ctl.cnt_op   = CNT_INC;
                  ctl.out_load = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_PREV;
               state_in   = S_F_WRITE;
            end
         end
         S_F_WRITE: begin
            ctl.wr_en       = 1'b1;
            ctl.wr_from_mem = 1'b1;
            ctl.idx_op      = IDX_DEC;
            state_in        = S_F_STEP;
         end
         S_R_READ: begin
            ctl.rd_en = 1'b1;
            state_in  = S_R_EVAL;
         end
         S_R_EVAL: begin
            if (sts.match) begin
               state_in = S_SHIFT;
            end else if (sts.idx_at_end) begin
               if (out_free) begin
                  ctl.out_load   = 1'b1;
                  ctl.out_status = ST_NOT_FOUND;
                  state_in       = S_IDLE;
               end
            end else begin
               ctl.idx_op = IDX_INC;
               state_in   = S_R_READ;
            end
         end
         S_SHIFT: begin
            if (sts.idx_tail) begin
               if (out_free) begin
                  ctl.cnt_op   = CNT_DEC;
                  ctl.out_load = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_NEXT;
               state_in   = S_S_WRITE;
            end
         end
         S_S_WRITE: begin
            ctl.wr_en       = 1'b1;
            ctl.wr_from_mem = 1'b1;
            ctl.idx_op      = IDX_INC;
            state_in        = S_SHIFT;
         end
         S_D_READ: begin
            ctl.rd_en = 1'b1;
            state_in  = S_D_EVAL;
         end
         S_D_EVAL: begin
            if (out_free) begin
               ctl.out_load     = 1'b1;
               ctl.out_from_mem = 1'b1;
               ctl.out_last     = sts.idx_at_end;
               if (sts.idx_at_end) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.idx_op = IDX_INC;
                  state_in   = S_D_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctl.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= CMD_FRONT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while occupied");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_D_READ || state_ff == S_D_EVAL)
         |-> !ctl.wr_en && ctl.cnt_op == CNT_HOLD)
      else $error("list modified outside an update sequence");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result beat dropped while stalled");

endmodule

`default_nettype wire

>>> tb/ordered_list_engine_test.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking bench for the ordered list engine. A shadow copy of the list
// predicts every reply beat from the accepted commands: front inserts, back
// appends, removes of the first match and front-to-back dumps, including the
// full, not-found and empty replies. Both channels idle at random, and the
// reply side holds off long enough once to back the engine up.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ole_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 96;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic signed [31:0] item_value;
      status_type         status;
      logic               last;
   } list_reply_type;

   class list_checker_type;
      logic signed [31:0] entries [CAPACITY];
      int                 count;
      list_reply_type     pending_replies [$];
      int                 errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function void push_reply(logic signed [31:0] iv, status_type st, logic lst);
         list_reply_type r;
         r.item_value = iv;
         r.status     = st;
         r.last       = lst;
         pending_replies.push_back(r);
      endfunction

      function logic signed [31:0] pick_entry();
         return entries[$urandom_range(0, count - 1)];
      endfunction

      function void apply_command(cmd_type c, logic signed [31:0] v);
         int hit;
         case (c)
            CMD_FRONT, CMD_BACK: begin
               if (count >= CAPACITY) begin
                  push_reply(0, ST_FULL, 1'b1);
               end else begin
                  if (c == CMD_FRONT) begin
                     for (int i = count; i > 0; i--) entries[i] = entries[i - 1];
                     entries[0] = v;
                  end else begin
                     entries[count] = v;
                  end
                  count++;
                  push_reply(0, ST_OK, 1'b1);
               end
            end
            CMD_REMOVE: begin
               hit = -1;
               for (int i = 0; i < count; i++)
                  if (hit < 0 && entries[i] == v) hit = i;
               if (hit < 0) begin
                  push_reply(0, ST_NOT_FOUND, 1'b1);
               end else begin
                  for (int j = hit; j + 1 < count; j++) entries[j] = entries[j + 1];
                  count--;
                  push_reply(0, ST_OK, 1'b1);
               end
            end
            default: begin
               if (count == 0) begin
                  push_reply(0, ST_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++)
                     push_reply(entries[i], ST_OK, i == count - 1);
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(logic signed [31:0] iv, logic [1:0] st, logic lst);
         list_reply_type r;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected beat value %0d status %0d last %0b",
                                      iv, st, lst));
         end else begin
            r = pending_replies.pop_front();
            if (iv !== r.item_value)
               report_mismatch($sformatf("item_value %0d, want %0d", iv, r.item_value));
            if (st !== r.status)
               report_mismatch($sformatf("status %0d, want %0d", st, r.status));
            if (lst !== r.last)
               report_mismatch($sformatf("last %0b, want %0b", lst, r.last));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   list_checker_type board;
   int               src_idle_pct;
   int               sink_idle_pct;
   bit               hold_request;

   ole_req_if req_chan();
   ole_rsp_if rsp_chan();

   ordered_list_engine #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap(int pct);
      return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 17) : 0;
   endfunction

   function automatic logic signed [31:0] draw_value();
      case ($urandom_range(0, 3))
         0: return $signed($urandom_range(0, 4)) - 2;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(input cmd_type c, input logic signed [31:0] v);
      int gap;
      gap = draw_gap(src_idle_pct);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= c;
      req_chan.value   <= v;
      do @(posedge clock); while (!req_chan.ready);
      board.apply_command(c, v);
   endtask

   task automatic send_random_command(int fill_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         send_command(CMD_DUMP, $urandom);
      else if (roll < 12 + fill_pct)
         send_command(($urandom_range(0, 1) != 0) ? CMD_BACK : CMD_FRONT, draw_value());
      else if (board.count > 0 && $urandom_range(0, 3) != 0)
         send_command(CMD_REMOVE, board.pick_entry());
      else
         send_command(CMD_REMOVE, draw_value());
   endtask

   // reply side: stall per beat, honor one long hold when asked
   initial begin : reply_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = draw_gap(sink_idle_pct);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         board.check_result(rsp_chan.item_value, rsp_chan.status, rsp_chan.last);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      board            = new();
      src_idle_pct     = 30;
      sink_idle_pct    = 30;
      hold_request     = 1'b0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.command <= CMD_FRONT;
      req_chan.value   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_DUMP, 0);
      send_command(CMD_REMOVE, 5);
      send_command(CMD_BACK, 32'sh7fff_ffff);
      send_command(CMD_FRONT, 32'sh8000_0000);
      send_command(CMD_BACK, -1);
      send_command(CMD_FRONT, 0);
      send_command(CMD_BACK, 0);
      send_command(CMD_DUMP, -1);
      send_command(CMD_REMOVE, 0);
      send_command(CMD_REMOVE, -1);
      send_command(CMD_REMOVE, 12345);

      // back the engine up while filling the list
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      hold_request  = 1'b1;
      while (board.count < CAPACITY) send_command(CMD_BACK, draw_value());
      send_command(CMD_FRONT, 32'sh7fff_ffff);
      send_command(CMD_BACK, 32'sh8000_0000);
      send_command(CMD_DUMP, 0);
      send_command(CMD_REMOVE, board.entries[board.count - 1]);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase / 2)
            0: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            1: begin src_idle_pct = 60; sink_idle_pct = 20; end
            2: begin src_idle_pct = 20; sink_idle_pct = 70; end
            default: begin src_idle_pct = 90; sink_idle_pct = 90; end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 8; n++)
            send_random_command((phase % 2 == 0) ? 25 : 65);
      end

      req_chan.valid <= 1'b0;
      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
